[design/mbf_pkg.sv]
package mbf_pkg;

  // Kernel geometry
  localparam int HALF_TAPS = 3;
  localparam int TAPS      = 2 * HALF_TAPS + 1;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int OUT_W    = 24;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int SUM_W    = PROD_W + 3;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W    = $clog2(TAPS);
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int DIST_W   = (HALF_TAPS > 1) ? $clog2(HALF_TAPS + 1) : 1;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [OUT_W-1:0]     filt_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [POS_W-1:0]            pos_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [DIST_W-1:0]           dist_t;

  // Q1.16 unity and half-LSB rounding offset
  localparam coef_t COEF_ONE   = coef_t'(1 << FRAC_W);
  localparam sum_t  ROUND_HALF = sum_t'(1 << (FRAC_W - 1));

  // Reset value of tap weight i: unity at the center, zero elsewhere
  function automatic coef_t coef_reset(input int i);
    coef_reset = (i == HALF_TAPS) ? COEF_ONE : '0;
  endfunction

  // Window position feeding tap j when the newest sample has frame index iv
  // and the output sits d samples behind it. Reflect about index 0 first,
  // then about the newest sample (whole-sample mirror at both ends).
  function automatic pos_t tap_pos(input pos_t iv, input dist_t d, input int j);
    logic signed [5:0] ivs;
    logic signed [5:0] idx;
    logic signed [5:0] r;
    logic signed [5:0] p;
    logic signed [5:0] last_pos;
    ivs      = 6'(iv);
    last_pos = 6'(TAPS - 1);
    idx      = ivs - 6'(d) - 6'(HALF_TAPS) + 6'(j);
    r        = (idx < 0) ? -idx : idx;
    if (r > ivs) begin
      r = (ivs <<< 1) - r;
    end
    if (r < 0) begin
      r = '0;
    end
    p = last_pos - ivs + r;
    if (p > last_pos) begin
      p = last_pos;
    end
    tap_pos = POS_W'(p);
  endfunction

endpackage

[design/mbf_in_if.sv]
interface mbf_in_if import mbf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

[design/mbf_out_if.sv]
interface mbf_out_if import mbf_pkg::*; ();
  logic  valid;
  logic  ready;
  filt_t filtered;
  logic  run_last;
  logic  short_frame;

  modport source (output valid, output filtered, output run_last, output short_frame,
                  input ready);
  modport sink   (input valid, input filtered, input run_last, input short_frame,
                  output ready);
endinterface

[design/mbf_cfg_if.sv]
interface mbf_cfg_if import mbf_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coef_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/mirror_boundary_fir_filter.sv]
// Pipeline: an accepted sample is held in the input register, and its result is
// registered in the output register.
// Throughput: one sample per cycle unless the output stalls; a long frame's last
// sample yields HALF_TAPS+1 results, and the sample channel pauses for the tail outputs.
// Datapath: mirrored tap operands in the input register, one multiply-and-sum pass.
// Reset (rst, synchronous, active high) clears the window, sample count, valids and
// tail sequencer, and loads the tap weights with unity at the center tap.
module mirror_boundary_fir_filter import mbf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mbf_cfg_if.sink      cfg,
  mbf_in_if.sink       samples,
  mbf_out_if.source    results
);

  // Tap weights and sample window (index 0 is the oldest sample)
  coef_t   coef [TAPS];
  sample_t win [TAPS];
  cnt_t    count;

  // Tail sequencer for the outputs after a frame's last sample
  logic    flush_active;
  dist_t   flush_d;
  pos_t    flush_iv;
  sample_t flush_win [TAPS];

  // Input and output registers
  logic    v1, v2;
  sample_t s1_op [TAPS];
  logic    s1_last, s1_short;
  filt_t   s2_filt;
  logic    s2_last, s2_short;

  logic    acc;
  logic    rdy1, rdy2;
  pos_t    iv_new;
  sample_t win_shift [TAPS];
  sample_t jsrc_win [TAPS];
  pos_t    jsrc_iv;
  dist_t   jsrc_d;
  logic    job_valid, job_last, job_short;
  sample_t job_op [TAPS];
  prod_t   prod [TAPS];
  sum_t    sum, rounded, shifted;

  // Handshakes and stage readiness
  assign rdy2          = !v2 || results.ready;
  assign rdy1          = !v1 || rdy2;
  assign samples.ready = rdy1 && !flush_active;
  assign acc           = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  // Frame index of the newest sample, held at TAPS-1 once the count saturates
  assign iv_new = (count == CNT_W'(TAPS)) ? POS_W'(TAPS - 1) : POS_W'(count);

  // Build the job for the input register: either the incoming sample or a tail output
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      win_shift[j] = (j < TAPS - 1) ? win[(j + 1) % TAPS] : samples.sample;
      jsrc_win[j]  = flush_active ? flush_win[j] : win_shift[j];
    end
    jsrc_iv   = flush_active ? flush_iv : iv_new;
    jsrc_d    = flush_active ? flush_d : DIST_W'(HALF_TAPS);
    job_short = !flush_active && samples.frame_end && (iv_new < POS_W'(HALF_TAPS));
    job_last  = flush_active ? (flush_d == '0) : job_short;
    job_valid = flush_active ||
                (acc && (samples.frame_end || (iv_new >= POS_W'(HALF_TAPS))));
    for (int j = 0; j < TAPS; j++) begin
      job_op[j] = jsrc_win[tap_pos(jsrc_iv, jsrc_d, j)];
    end
  end

  // Write tap weights; indexes past the kernel are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TAPS; j++) begin
        coef[j] <= coef_reset(j);
      end
    end else if (cfg.valid && (cfg.index < CFG_IDX_W'(TAPS))) begin
      coef[POS_W'(cfg.index)] <= cfg.data;
    end
  end

  // Advance the window and count; clear both after a frame's last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int j = 0; j < TAPS; j++) begin
        win[j] <= '0;
      end
    end else if (acc) begin
      if (samples.frame_end) begin
        count <= '0;
        for (int j = 0; j < TAPS; j++) begin
          win[j] <= '0;
        end
      end else begin
        win <= win_shift;
        if (count != CNT_W'(TAPS)) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Issue the remaining tail outputs, one per free input-register slot
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_active <= 1'b0;
      flush_d      <= '0;
    end else if (flush_active) begin
      if (rdy1) begin
        if (flush_d == '0) begin
          flush_active <= 1'b0;
        end else begin
          flush_d <= flush_d - 1'b1;
        end
      end
    end else if (acc && samples.frame_end && (iv_new >= POS_W'(HALF_TAPS))) begin
      flush_active <= 1'b1;
      flush_d      <= DIST_W'(HALF_TAPS - 1);
    end
  end

  // Snapshot the frame tail for the sequencer
  always_ff @(posedge clk) begin
    if (acc && samples.frame_end) begin
      flush_win <= win_shift;
      flush_iv  <= iv_new;
    end
  end

  // Register valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= job_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // Input register: mirrored tap operands
  always_ff @(posedge clk) begin
    if (rdy1 && job_valid) begin
      s1_op    <= job_op;
      s1_last  <= job_last;
      s1_short <= job_short;
    end
  end

  // Multiply, sum and round half up; |sum| <= 7 * 2^32, so the result never leaves 24 bits
  always_comb begin
    sum = '0;
    for (int j = 0; j < TAPS; j++) begin
      prod[j] = coef[j] * s1_op[j];
      sum     = sum + SUM_W'(prod[j]);
    end
    rounded = sum + ROUND_HALF;
    shifted = rounded >>> FRAC_W;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_filt  <= s1_short ? '0 : OUT_W'(shifted);
      s2_last  <= s1_last;
      s2_short <= s1_short;
    end
  end

  assign results.valid       = v2;
  assign results.filtered    = s2_filt;
  assign results.run_last    = s2_last;
  assign results.short_frame = s2_short;

  // A tail in progress holds off new samples
  assert property (@(posedge clk) disable iff (rst) flush_active |-> !samples.ready)
    else $error("sample accepted during frame tail");

  // A long frame's last sample starts the tail sequencer
  assert property (@(posedge clk) disable iff (rst)
    acc && samples.frame_end && (iv_new >= POS_W'(HALF_TAPS))
      |=> flush_active && (flush_d == DIST_W'(HALF_TAPS - 1)))
    else $error("frame tail not started");

  // Frame end clears the sample count
  assert property (@(posedge clk) disable iff (rst)
    acc && samples.frame_end |=> (count == '0))
    else $error("sample count not cleared at frame end");

  // A short-frame result is zero and closes the frame
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.short_frame |-> (results.filtered == '0) && results.run_last)
    else $error("malformed short-frame result");

  // The tail keeps going until its last output has been issued
  assert property (@(posedge clk) disable iff (rst)
    flush_active && (flush_d != '0) |=> flush_active)
    else $error("frame tail ended early");

endmodule
